[rtl/core/wrs_pkg.sv]
// wrs_pkg: widths, request codes and sequencer states of the running stdev core
// no dependencies; compiled first, used by the channel interfaces and the core
`default_nettype none

package wrs_pkg;

  // field and state widths
  localparam int SAMPLE_W     = 32;
  localparam int RESULT_W     = 32;
  localparam int COUNT_W      = 32;
  localparam int MEAN_EXTRA_W = 16;
  localparam int MEAN_W       = SAMPLE_W + MEAN_EXTRA_W;
  localparam int DELTA_W      = MEAN_W + 1;
  localparam int SUM_W        = 64;
  localparam int ROOT_W       = SUM_W / 2;

  // divide, root and multiply iteration counts and digit widths
  localparam int DIV_STEPS_SAMPLE = MEAN_W;
  localparam int DIV_STEPS_FINAL  = SUM_W;
  localparam int SQRT_STEPS       = ROOT_W;
  localparam int MUL_DIGIT_W      = 16;
  localparam int MUL_DIGITS       = MEAN_W / MUL_DIGIT_W;
  localparam int STEP_W           = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // request codes
  localparam logic REQ_ACCUM = 1'b0;
  localparam logic REQ_FINAL = 1'b1;

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_DIV  = 8'b0000_0010,
    ST_MEAN = 8'b0000_0100,
    ST_DEV  = 8'b0000_1000,
    ST_MUL  = 8'b0001_0000,
    ST_ACC  = 8'b0010_0000,
    ST_SUM  = 8'b0100_0000,
    ST_SQRT = 8'b1000_0000
  } wrs_state_t;

endpackage

`default_nettype wire

[rtl/core/wrs_sample_if.sv]
// wrs_sample_if: valid/ready channel carrying one request transaction
// depends on wrs_pkg for the sample width
`default_nettype none

interface wrs_sample_if;
  import wrs_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                       sample_is_null;

  modport source (output valid, req_type, sample_value, sample_is_null, input ready);
  modport sink   (input valid, req_type, sample_value, sample_is_null, output ready);
endinterface

`default_nettype wire

[rtl/core/wrs_result_if.sv]
// wrs_result_if: valid/ready channel carrying one result transaction
// depends on wrs_pkg for the result and count widths
`default_nettype none

interface wrs_result_if;
  import wrs_pkg::*;

  logic                valid;
  logic                ready;
  logic [RESULT_W-1:0] std_dev;
  logic [COUNT_W-1:0]  sample_count;

  modport source (output valid, std_dev, sample_count, input ready);
  modport sink   (input valid, std_dev, sample_count, output ready);
endinterface

`default_nettype wire

[rtl/core/welford_running_stdev_core.sv]
// Running sample standard deviation (Welford) with one shared subtract/compare unit.
// Channels: samples (request in) and results (stdev + count out), valid/ready.
// A request transaction is taken when samples.valid and samples.ready are high at a
// clock edge. req_type REQ_ACCUM adds a sample (skipped if sample_is_null), REQ_FINAL
// emits one result transaction and clears the group state.
// Timing: samples.ready is high only while the sequencer is idle.
//   null sample      : ready stays high
//   non-null sample  : 48 restoring-divide steps for delta/count, then mean update,
//                      deviation, three 48x16 multiply digits, final accumulate,
//                      sum
//   finalize, n > 1  : 64 divide steps for sum/(n-1), 32 root steps, then the result
//                      register is loaded
//   finalize, n <= 1 : no divide or root steps; the result register is loaded
// The divide and root steps share one 37-bit subtract/compare unit, one bit per cycle.
// Results sit in an output register; the core keeps taking samples while a result
// waits. A finalize that finishes while the result register is still full waits for
// results.ready before it loads the new result and clears the group.
// Reset (rst, synchronous) clears count, mean, sum, the sequencer and results.valid.
`default_nettype none

module welford_running_stdev_core (
  input  logic         clk,
  input  logic         rst,
  wrs_sample_if.sink   samples,
  wrs_result_if.source results
);
  import wrs_pkg::*;

  // group state
  logic [COUNT_W-1:0]       count;
  logic signed [MEAN_W-1:0] mean;
  logic [SUM_W-1:0]         sum;

  // sequencer
  wrs_state_t        state;
  logic [STEP_W-1:0] step;
  logic              is_fin;

  // per-item working registers
  logic signed [MEAN_W-1:0]  xs;
  logic signed [DELTA_W-1:0] delta;
  logic [COUNT_W-1:0]        divisor;
  logic [COUNT_W-1:0]        div_rem;
  logic [SUM_W-1:0]          quo;
  logic [ROOT_W-1:0]         root;
  logic [ROOT_W+1:0]         sq_rem;
  logic [MEAN_W-1:0]         mul_a;
  logic [MEAN_W-1:0]         mul_b;
  logic [SUM_W-1:0]          pp;
  logic [2*MEAN_W-1:0]       acc;

  // output register
  logic                out_valid;
  logic [RESULT_W-1:0] out_std;
  logic [COUNT_W-1:0]  out_cnt;

  // combinational helpers
  logic [COUNT_W-1:0]        count_inc;
  logic signed [MEAN_W-1:0]  xs_in;
  logic signed [DELTA_W-1:0] delta_in;
  logic [DELTA_W-1:0]        delta_in_mag;
  logic signed [MEAN_W+1:0]  q_signed;
  logic signed [MEAN_W+1:0]  nm_wide;
  logic signed [MEAN_W-1:0]  nm;
  logic signed [DELTA_W-1:0] dev;
  logic [DELTA_W-1:0]        dev_mag;
  logic [DELTA_W-1:0]        delta_mag;
  logic                      sign_clash;
  logic [SUM_W:0]            sum_wide;
  logic                      slot_free;
  logic                      result_load;

  // shared subtract/compare unit
  logic [35:0] sub_a;
  logic [35:0] sub_b;
  logic [36:0] sub_diff;
  logic        sub_ge;

  always_comb begin
    case (state)
      ST_DIV: begin
        sub_a = {3'b000, div_rem, quo[SUM_W-1]};
        sub_b = {4'b0000, divisor};
      end
      ST_SQRT: begin
        sub_a = {sq_rem, quo[SUM_W-1:SUM_W-2]};
        sub_b = {2'b00, root, 2'b01};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
    sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    sub_ge   = ~sub_diff[36];
  end

  // accept-side arithmetic
  always_comb begin
    count_inc    = (count == COUNT_MAX) ? count : count + 1'b1;
    xs_in        = $signed({samples.sample_value, {MEAN_EXTRA_W{1'b0}}});
    delta_in     = $signed({xs_in[MEAN_W-1], xs_in}) - $signed({mean[MEAN_W-1], mean});
    delta_in_mag = delta_in[DELTA_W-1] ? DELTA_W'(-delta_in) : delta_in;
  end

  // mean update with clamp to the 48-bit signed range
  always_comb begin
    q_signed = delta[DELTA_W-1] ? -$signed({2'b00, quo[MEAN_W-1:0]})
                                :  $signed({2'b00, quo[MEAN_W-1:0]});
    nm_wide  = $signed({{2{mean[MEAN_W-1]}}, mean}) + q_signed;
    if (nm_wide > $signed({3'b000, {(MEAN_W-1){1'b1}}})) begin
      nm = $signed({1'b0, {(MEAN_W-1){1'b1}}});
    end else if (nm_wide < $signed({3'b111, {(MEAN_W-1){1'b0}}})) begin
      nm = $signed({1'b1, {(MEAN_W-1){1'b0}}});
    end else begin
      nm = nm_wide[MEAN_W-1:0];
    end
  end

  // deviation from the new mean and the product operands
  always_comb begin
    dev         = $signed({xs[MEAN_W-1], xs}) - $signed({mean[MEAN_W-1], mean});
    dev_mag     = dev[DELTA_W-1] ? DELTA_W'(-dev) : dev;
    delta_mag   = delta[DELTA_W-1] ? DELTA_W'(-delta) : delta;
    sign_clash  = (delta[DELTA_W-1] && !dev[DELTA_W-1] && (dev != '0)) ||
                  (!delta[DELTA_W-1] && (delta != '0) && dev[DELTA_W-1]);
    sum_wide    = {1'b0, sum} + {1'b0, acc[2*MEAN_W-1:2*MEAN_W-SUM_W]};
    slot_free   = !out_valid || results.ready;
    result_load = (state == ST_SQRT) && !is_fin && slot_free;
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      is_fin    <= 1'b0;
      count     <= '0;
      mean      <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      // result register handshake
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (samples.valid) begin
            if (samples.req_type == REQ_FINAL) begin
              is_fin  <= (count > COUNT_W'(1));
              divisor <= count - 1'b1;
              quo     <= sum;
              div_rem <= '0;
              root    <= '0;
              sq_rem  <= '0;
              step    <= STEP_W'(DIV_STEPS_FINAL - 1);
              state   <= (count > COUNT_W'(1)) ? ST_DIV : ST_SQRT;
            end else if (!samples.sample_is_null) begin
              is_fin  <= 1'b0;
              count   <= count_inc;
              xs      <= xs_in;
              delta   <= delta_in;
              divisor <= count_inc;
              quo     <= {delta_in_mag[MEAN_W-1:0], {(SUM_W-MEAN_W){1'b0}}};
              div_rem <= '0;
              step    <= STEP_W'(DIV_STEPS_SAMPLE - 1);
              state   <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          // one restoring-divide step
          div_rem <= sub_ge ? sub_diff[COUNT_W-1:0] : sub_a[COUNT_W-1:0];
          quo     <= {quo[SUM_W-2:0], sub_ge};
          if (step == '0) begin
            sq_rem <= '0;
            root   <= '0;
            step   <= STEP_W'(SQRT_STEPS - 1);
            state  <= is_fin ? ST_SQRT : ST_MEAN;
          end else begin
            step <= step - 1'b1;
          end
        end
        ST_MEAN: begin
          mean  <= nm;
          state <= ST_DEV;
        end
        ST_DEV: begin
          mul_a <= delta_mag[MEAN_W-1:0];
          mul_b <= sign_clash ? '0 : dev_mag[MEAN_W-1:0];
          pp    <= '0;
          acc   <= '0;
          step  <= STEP_W'(MUL_DIGITS - 1);
          state <= ST_MUL;
        end
        ST_MUL: begin
          // one 48x16 digit product per cycle, top digit first
          pp    <= {{(SUM_W-MEAN_W){1'b0}}, mul_a} *
                   {{(SUM_W-MUL_DIGIT_W){1'b0}}, mul_b[MEAN_W-1:MEAN_W-MUL_DIGIT_W]};
          mul_b <= {mul_b[MEAN_W-MUL_DIGIT_W-1:0], {MUL_DIGIT_W{1'b0}}};
          acc   <= {acc[2*MEAN_W-MUL_DIGIT_W-1:0], {MUL_DIGIT_W{1'b0}}} +
                   {{(2*MEAN_W-SUM_W){1'b0}}, pp};
          step  <= step - 1'b1;
          if (step == '0) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          acc   <= {acc[2*MEAN_W-MUL_DIGIT_W-1:0], {MUL_DIGIT_W{1'b0}}} +
                   {{(2*MEAN_W-SUM_W){1'b0}}, pp};
          state <= ST_SUM;
        end
        ST_SUM: begin
          // saturating add of the product term
          sum   <= sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
          state <= ST_IDLE;
        end
        ST_SQRT: begin
          if (is_fin) begin
            // one root digit per cycle
            sq_rem <= sub_ge ? sub_diff[ROOT_W+1:0] : sub_a[ROOT_W+1:0];
            root   <= {root[ROOT_W-2:0], sub_ge};
            quo    <= {quo[SUM_W-3:0], 2'b00};
            step   <= step - 1'b1;
            if (step == '0) begin
              is_fin <= 1'b0;
            end
          end else if (slot_free) begin
            // result transaction and group clear
            out_std   <= (count > COUNT_W'(1)) ? root : '0;
            out_cnt   <= count;
            count     <= '0;
            mean      <= '0;
            sum       <= '0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign samples.ready        = (state == ST_IDLE);
  assign results.valid        = out_valid;
  assign results.std_dev      = out_std;
  assign results.sample_count = out_cnt;

  // divisor is never zero while dividing
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (divisor != '0))
    else $error("divide started with zero divisor");

  // a sample reaching the mean update has been counted
  a_count_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MEAN) |-> (count != '0) && (divisor == count))
    else $error("mean update without a counted sample");

  // root remainder bound of the digit recurrence
  a_sqrt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQRT) |-> ({1'b0, sq_rem} <= {1'b0, root, 1'b0}))
    else $error("root remainder out of range");

  // a new result comes only from the finalize step, and leaves the group cleared
  a_result_clear: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_SQRT) && (count == '0) && (sum == '0) &&
    (mean == '0))
    else $error("result transaction without group clear");

endmodule

`default_nettype wire
